// ===== hw/rtl/bitmap_frame_allocator_assert.svh =====
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
// ----------------------------------------------------------------
// Bitmap frame allocator assertion macros
// Same-cycle and next-cycle implications on the port clock.
// ----------------------------------------------------------------

// antecedent implies consequent in the same cycle, outside reset
`define BFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("bitmap frame allocator check failed");

// antecedent implies consequent in the next cycle, reset included
`define BFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("bitmap frame allocator check failed");

`endif

// ===== hw/rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------
// Bitmap frame allocator package
// Shared constants, operation codes and control types.
// ----------------------------------------------------------------
package bfa_pkg;

    localparam int MAX_FRAMES_DEF = 4096;
    localparam int FRAME_SHIFT    = 12;
    localparam int WORD_BITS      = 32;
    localparam int RESET_MEM_KB   = 16384;
    localparam int RESET_RESERVED = 256;
    localparam int QUEUE_DEPTH    = 2;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 32;
    localparam int FADDR_W    = 24;
    localparam int COUNT_W    = 13;
    localparam int MEM_KB_W   = 15;
    localparam int RESV_W     = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEM_KB   = 1'b0,
        CFG_RESERVED = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        t_op  op;
        logic oor;
    } t_ctl;

endpackage

// ===== hw/rtl/bfa_front.sv =====
// ----------------------------------------------------------------
// Bitmap frame allocator front end
// Accepts commands, decodes the frame number and range-checks frees.
// ----------------------------------------------------------------
module bfa_front #(
    parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF
) (
    input  logic                       i_start,
    input  logic [bfa_pkg::OP_W-1:0]   i_operation,
    input  logic [bfa_pkg::ADDR_W-1:0] i_address,
    input  logic                       i_q_full,
    output logic                       o_busy,
    output logic                       o_push,
    output bfa_pkg::t_ctl              o_ctl,
    output logic [$clog2(MAX_FRAMES)-1:0] o_frame
);
    import bfa_pkg::*;

    localparam int FW = $clog2(MAX_FRAMES);

    logic [ADDR_W-1:0] frame_num;

    assign frame_num = i_address >> FRAME_SHIFT;
    assign o_busy    = i_q_full;
    assign o_push    = i_start && !i_q_full;
    assign o_frame   = frame_num[FW-1:0];

    always_comb begin
        o_ctl.op  = t_op'(i_operation);
        o_ctl.oor = 1'b0;
        if (o_ctl.op == OP_FREE) begin
            o_ctl.oor = (frame_num >= ADDR_W'(MAX_FRAMES));
        end
    end

endmodule

// ===== hw/rtl/bfa_queue.sv =====
// ----------------------------------------------------------------
// Bitmap frame allocator command queue
// Small FIFO between the front end and the execution unit.
// ----------------------------------------------------------------
module bfa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bfa_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    import bfa_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;

    assign o_data  = r_data[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/bfa_back.sv =====
// ----------------------------------------------------------------
// Bitmap frame allocator execution unit
// Holds the frame map, full-word summary and count; runs commands.
// ----------------------------------------------------------------
module bfa_back #(
    parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  bfa_pkg::t_ctl                 i_ctl,
    input  logic [$clog2(MAX_FRAMES)-1:0] i_frame,
    input  logic [bfa_pkg::MEM_KB_W-1:0]  i_mem_kb,
    input  logic [bfa_pkg::RESV_W-1:0]    i_reserved,
    output logic                          o_pop,
    output logic                          o_result_valid,
    output logic [bfa_pkg::FADDR_W-1:0]   o_frame_address,
    output logic                          o_ok,
    output logic [bfa_pkg::COUNT_W-1:0]   o_used_count
);
    import bfa_pkg::*;

    localparam int FW     = $clog2(MAX_FRAMES);
    localparam int WORDS  = MAX_FRAMES / WORD_BITS;
    localparam int WIW    = (FW > 5) ? FW - 5 : 1;
    localparam int CW     = $clog2(MAX_FRAMES + 1);
    localparam int TW     = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int RST_N  = (RESET_RESERVED > MAX_FRAMES) ? MAX_FRAMES : RESET_RESERVED;

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORD_BITS-1:0] r_rd_data;

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic               r_oor, n_oor;
    logic               r_fail, n_fail;
    logic [FW-1:0]      r_frame, n_frame;
    logic [WIW-1:0]     r_widx, n_widx;
    logic [WORDS-1:0]   r_valid, n_valid;
    logic [WORDS-1:0]   r_full, n_full;
    logic [CW-1:0]      r_used, n_used;
    logic [CW-1:0]      r_init_n, n_init_n;
    logic               r_out_valid, n_out_valid;
    logic [FADDR_W-1:0] r_out_addr, n_out_addr;
    logic               r_out_ok, n_out_ok;
    logic [COUNT_W-1:0] r_out_used, n_out_used;

    logic [TW-1:0]        kb_frames, total, resv_t;
    logic [TW:0]          word_lim;
    logic [CW-1:0]        nsat;
    logic [WORDS-1:0]     elig, cand, init_full, rst_full;
    logic                 found;
    logic [WIW-1:0]       enc_idx;
    logic                 rd_en, wr_en;
    logic [WIW-1:0]       rd_addr;
    logic [WORD_BITS-1:0] word, wr_data;
    logic [4:0]           bsel;
    logic [FW-1:0]        alloc_frame;

    function automatic logic [WORD_BITS-1:0] init_word(input logic [WIW-1:0] w,
                                                        input logic [CW-1:0]  n);
        logic [31:0] hi;
        hi = 32'(n) >> 5;
        if (32'(w) < hi) begin
            init_word = '1;
        end else if (32'(w) == hi) begin
            init_word = (32'd1 << n[4:0]) - 32'd1;
        end else begin
            init_word = '0;
        end
    endfunction

    assign kb_frames = TW'(i_mem_kb >> 2);
    assign total     = (kb_frames > TW'(MAX_FRAMES)) ? TW'(MAX_FRAMES) : kb_frames;
    assign resv_t    = TW'(i_reserved);
    assign nsat      = CW'((resv_t > TW'(MAX_FRAMES)) ? TW'(MAX_FRAMES) : resv_t);
    assign word_lim  = ({1'b0, total} + (TW+1)'(31)) >> 5;

    always_comb begin
        for (int w = 0; w < WORDS; w++) begin
            elig[w]      = ((TW+1)'(w) < word_lim);
            init_full[w] = (32'((w + 1) * WORD_BITS) <= 32'(nsat));
            rst_full[w]  = ((w + 1) * WORD_BITS <= RST_N);
        end
    end

    assign cand  = ~r_full & elig;
    assign found = |cand;

    always_comb begin
        enc_idx = '0;
        for (int w = WORDS - 1; w >= 0; w--) begin
            if (cand[w]) begin
                enc_idx = WIW'(w);
            end
        end
    end

    assign word = r_valid[r_widx] ? r_rd_data : init_word(r_widx, r_init_n);

    always_comb begin
        bsel = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!word[b]) begin
                bsel = 5'(b);
            end
        end
    end

    assign alloc_frame = FW'({r_widx, bsel});

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_oor       = r_oor;
        n_fail      = r_fail;
        n_frame     = r_frame;
        n_widx      = r_widx;
        n_valid     = r_valid;
        n_full      = r_full;
        n_used      = r_used;
        n_init_n    = r_init_n;
        n_out_valid = 1'b0;
        n_out_addr  = '0;
        n_out_ok    = 1'b0;
        n_out_used  = COUNT_W'(r_used);
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_data     = word;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_op    = i_ctl.op;
                    n_oor   = i_ctl.oor;
                    n_frame = i_frame;
                    unique case (i_ctl.op)
                        OP_INIT: begin
                            n_valid     = '0;
                            n_full      = init_full;
                            n_used      = nsat;
                            n_init_n    = nsat;
                            n_out_valid = 1'b1;
                            n_out_used  = COUNT_W'(nsat);
                        end
                        OP_ALLOC: begin
                            rd_en   = 1'b1;
                            rd_addr = enc_idx;
                            n_widx  = enc_idx;
                            n_fail  = !found || (TW'(r_used) >= total);
                            n_state = ST_EXEC;
                        end
                        OP_FREE: begin
                            rd_en   = 1'b1;
                            rd_addr = WIW'(i_frame >> 5);
                            n_widx  = WIW'(i_frame >> 5);
                            n_state = ST_EXEC;
                        end
                        OP_NOP: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_EXEC: begin
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
                if (r_op == OP_ALLOC) begin
                    if (!r_fail && (32'(alloc_frame) < 32'(total))) begin
                        wr_en           = 1'b1;
                        wr_data         = word | (32'd1 << bsel);
                        n_valid[r_widx] = 1'b1;
                        n_full[r_widx]  = &wr_data;
                        n_used          = r_used + CW'(1);
                        n_out_ok        = 1'b1;
                        n_out_addr      = FADDR_W'(32'(alloc_frame) << FRAME_SHIFT);
                        n_out_used      = COUNT_W'(r_used + CW'(1));
                    end
                end else if (!r_oor && word[r_frame[4:0]]) begin
                    wr_en           = 1'b1;
                    wr_data         = word & ~(32'd1 << r_frame[4:0]);
                    n_valid[r_widx] = 1'b1;
                    n_full[r_widx]  = 1'b0;
                    n_used          = (r_used == '0) ? '0 : r_used - CW'(1);
                    n_out_ok        = 1'b1;
                    n_out_used      = COUNT_W'((r_used == '0) ? '0 : r_used - CW'(1));
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_full      <= rst_full;
            r_used      <= CW'(RST_N);
            r_init_n    <= CW'(RST_N);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_full      <= n_full;
            r_used      <= n_used;
            r_init_n    <= n_init_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_oor      <= n_oor;
        r_fail     <= n_fail;
        r_frame    <= n_frame;
        r_widx     <= n_widx;
        r_out_addr <= n_out_addr;
        r_out_ok   <= n_out_ok;
        r_out_used <= n_out_used;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_widx] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_result_valid  = r_out_valid;
    assign o_frame_address = r_out_addr;
    assign o_ok            = r_out_ok;
    assign o_used_count    = r_out_used;

endmodule

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// Results are registered: allocate and free pass the command queue, the map word
// read and the update; reinitialize and no-op skip the read and the update.
// Throughput: one reinitialize per cycle while commands are queued; an allocate
// or free holds the execution unit through its map word read, then its update,
// and a 2-deep command queue absorbs bursts. Reset: synchronous; the map reads as
// the reserved frames set at once through per-word valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------
// Bitmap frame allocator
// First-fit page frame allocator over a one-bit-per-frame map.
// ----------------------------------------------------------------
module bitmap_frame_allocator #(
    parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [bfa_pkg::OP_W-1:0]       i_operation,
    input  logic [bfa_pkg::ADDR_W-1:0]     i_address,
    output logic                           o_result_valid,
    output logic [bfa_pkg::FADDR_W-1:0]    o_frame_address,
    output logic                           o_ok,
    output logic [bfa_pkg::COUNT_W-1:0]    o_used_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bfa_pkg::*;

    localparam int FW = $clog2(MAX_FRAMES);
    localparam int QW = $bits(t_ctl) + FW;

    logic [MEM_KB_W-1:0] r_mem_kb;
    logic [RESV_W-1:0]   r_reserved;

    logic          q_full, q_empty, push, pop;
    t_ctl          front_ctl, back_ctl;
    logic [FW-1:0] front_frame, back_frame;
    logic [QW-1:0] q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_kb   <= MEM_KB_W'(RESET_MEM_KB);
            r_reserved <= RESV_W'(RESET_RESERVED);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_MEM_KB:   r_mem_kb   <= i_cfg_data[MEM_KB_W-1:0];
                CFG_RESERVED: r_reserved <= i_cfg_data[RESV_W-1:0];
            endcase
        end
    end

    bfa_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .i_start     (start),
        .i_operation (i_operation),
        .i_address   (i_address),
        .i_q_full    (q_full),
        .o_busy      (busy),
        .o_push      (push),
        .o_ctl       (front_ctl),
        .o_frame     (front_frame)
    );

    bfa_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_ctl, front_frame}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign back_ctl   = t_ctl'(q_out[QW-1:FW]);
    assign back_frame = q_out[FW-1:0];

    bfa_back #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_ctl           (back_ctl),
        .i_frame         (back_frame),
        .i_mem_kb        (r_mem_kb),
        .i_reserved      (r_reserved),
        .o_pop           (pop),
        .o_result_valid  (o_result_valid),
        .o_frame_address (o_frame_address),
        .o_ok            (o_ok),
        .o_used_count    (o_used_count)
    );

endmodule

// ===== hw/rtl/bfa_checker.sv =====
// ----------------------------------------------------------------
// Bitmap frame allocator port checker
// Result consistency and reset behaviour seen at the top ports.
// ----------------------------------------------------------------
`include "bitmap_frame_allocator_assert.svh"

module bfa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_result_valid,
    input logic [bfa_pkg::FADDR_W-1:0]    o_frame_address,
    input logic                           o_ok,
    input logic [bfa_pkg::COUNT_W-1:0]    o_used_count
);
    `BFA_ASSERT_NEXT(a_rst_quiet, !i_rst_n, !o_result_valid && !busy)
    `BFA_ASSERT_NOW(a_fail_zero_addr, o_result_valid && !o_ok, o_frame_address == '0)
    `BFA_ASSERT_NOW(a_addr_aligned, o_result_valid, o_frame_address[11:0] == '0)
    `BFA_ASSERT_NOW(a_alloc_counted, o_result_valid && o_frame_address != '0, o_ok && o_used_count != '0)

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);

// ===== tb/bitmap_frame_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------
// Bitmap frame allocator testbench
// Sends allocate, free, reinitialize and no-op commands under several
// memory-size and reserved-frame settings, and checks every answer against
// a first-fit model of the frame map kept inside the bench.
// ----------------------------------------------------------------
module bitmap_frame_allocator_test;
    import bfa_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int STORE_FRAMES  = MAX_FRAMES_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 75;

    typedef struct packed {
        logic [FADDR_W-1:0] frame_address;
        logic               ok;
        logic [COUNT_W-1:0] used_count;
    } t_answer;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       i_operation     = OP_NOP;
    logic [ADDR_W-1:0]     i_address       = '0;
    logic                  o_result_valid;
    logic [FADDR_W-1:0]    o_frame_address;
    logic                  o_ok;
    logic [COUNT_W-1:0]    o_used_count;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = CFG_MEM_KB;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    bit          frame_used [STORE_FRAMES];
    int unsigned model_used;
    int unsigned mem_kb_cfg;
    int unsigned reserved_cfg;

    t_answer     pending_answers [$];
    int unsigned failures      = 0;
    int unsigned cycle_count   = 0;
    int unsigned items_sent    = 0;
    int unsigned answers_seen  = 0;
    int unsigned frames_given  = 0;
    int unsigned refusals      = 0;
    int unsigned frames_freed  = 0;
    int unsigned reg_writes    = 0;

    bitmap_frame_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_address       (i_address),
        .o_result_valid  (o_result_valid),
        .o_frame_address (o_frame_address),
        .o_ok            (o_ok),
        .o_used_count    (o_used_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic int unsigned frame_total();
        int unsigned t;
        t = mem_kb_cfg / 4;
        return (t > STORE_FRAMES) ? STORE_FRAMES : t;
    endfunction

    function automatic void reload_map();
        int unsigned n;
        n = (reserved_cfg > STORE_FRAMES) ? STORE_FRAMES : reserved_cfg;
        for (int f = 0; f < STORE_FRAMES; f++)
            frame_used[f] = (f < n);
        model_used = n;
    endfunction

    function automatic t_answer predict_answer(t_op op, logic [ADDR_W-1:0] addr);
        t_answer     a;
        int unsigned total;
        int unsigned f;
        a = '0;
        case (op)
            OP_ALLOC: begin
                total = frame_total();
                f = total;
                if (model_used < total) begin
                    for (f = 0; f < total; f++)
                        if (!frame_used[f])
                            break;
                end
                if (f < total) begin
                    frame_used[f] = 1'b1;
                    model_used++;
                    a.frame_address = FADDR_W'(f << FRAME_SHIFT);
                    a.ok = 1'b1;
                    frames_given++;
                end else begin
                    refusals++;
                end
            end
            OP_FREE: begin
                f = addr >> FRAME_SHIFT;
                if (f < STORE_FRAMES && frame_used[f]) begin
                    frame_used[f] = 1'b0;
                    if (model_used > 0)
                        model_used--;
                    a.ok = 1'b1;
                    frames_freed++;
                end
            end
            OP_INIT: reload_map();
            default: ;
        endcase
        a.used_count = model_used[COUNT_W-1:0];
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_result_valid) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
                $error("unexpected answer: frame_address %h ok %b used_count %0d",
                       o_frame_address, o_ok, o_used_count);
                failures++;
            end else begin
                want = pending_answers.pop_front();
                if (o_frame_address !== want.frame_address) begin
                    $error("frame_address: expected %h, got %h",
                           want.frame_address, o_frame_address);
                    failures++;
                end
                if (o_ok !== want.ok) begin
                    $error("ok: expected %b, got %b", want.ok, o_ok);
                    failures++;
                end
                if (o_used_count !== want.used_count) begin
                    $error("used_count: expected %0d, got %0d",
                           want.used_count, o_used_count);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d answers outstanding",
                   cycle_count, pending_answers.size());
            $display("** bitmap_frame_allocator: FAILED **");
            $finish;
        end
    end

    // called at a falling edge; returns at a falling edge with start still high
    task automatic send_command(t_op op, logic [ADDR_W-1:0] addr);
        start       <= 1'b1;
        i_operation <= op;
        i_address   <= addr;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        pending_answers.push_back(predict_answer(op, addr));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic hold_off(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        if (idx == CFG_MEM_KB)
            mem_kb_cfg = value;
        else
            reserved_cfg = value[RESV_W-1:0];
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_limits(int unsigned mem_kb, int unsigned reserved);
        write_register(CFG_MEM_KB, CFG_DATA_W'(mem_kb));
        write_register(CFG_RESERVED, CFG_DATA_W'(reserved));
        send_command(OP_INIT, $urandom());
    endtask

    task automatic test_reset_state();
        send_command(OP_ALLOC, '0);
        send_command(OP_FREE, 32'h0000_0000);
        send_command(OP_FREE, 32'h0000_0ABC);
        send_command(OP_FREE, 32'hFFFF_FFFF);
        send_command(OP_FREE, 32'h00FF_F000);
        send_command(OP_NOP, 32'hFFFF_FFFF);
        send_command(OP_ALLOC, 32'hFFFF_FFFF);
        send_command(OP_INIT, '0);
    endtask

    task automatic test_partial_word();
        // total of 257 frames: one live bit in the last map word
        set_limits(1031, RESET_RESERVED);
        send_command(OP_ALLOC, '0);
        send_command(OP_ALLOC, '0);
        send_command(OP_FREE, 32'h0010_0FFF);
        send_command(OP_ALLOC, '0);
    endtask

    task automatic test_config_extremes();
        write_register(CFG_MEM_KB, '0);
        send_command(OP_ALLOC, '0);
        set_limits(15'h7FFF, 15'h7FFF);
        send_command(OP_ALLOC, '0);
        send_command(OP_FREE, 32'h00FF_F123);
        send_command(OP_ALLOC, '0);
        // frames above the total stay freeable
        write_register(CFG_MEM_KB, 1024);
        send_command(OP_FREE, 32'h0012_C000);
        send_command(OP_ALLOC, '0);
        set_limits(4, 0);
        send_command(OP_ALLOC, '0);
        send_command(OP_ALLOC, '0);
    endtask

    task automatic send_random_command();
        int unsigned       pick;
        int unsigned       seed_frame;
        int unsigned       f;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(99);
        addr = $urandom();
        if (pick < 50) begin
            send_command(OP_ALLOC, addr);
        end else if (pick < 82) begin
            seed_frame = $urandom_range(STORE_FRAMES - 1);
            f = seed_frame;
            for (int k = 0; k < STORE_FRAMES; k++) begin
                if (frame_used[(seed_frame + k) % STORE_FRAMES]) begin
                    f = (seed_frame + k) % STORE_FRAMES;
                    break;
                end
            end
            send_command(OP_FREE, (f << FRAME_SHIFT) | (addr & 32'h0000_0FFF));
        end else if (pick < 90) begin
            f = $urandom_range(STORE_FRAMES - 1);
            send_command(OP_FREE, (f << FRAME_SHIFT) | (addr & 32'h0000_0FFF));
        end else if (pick < 95) begin
            send_command(OP_FREE, addr);
        end else if (pick < 98) begin
            send_command(OP_INIT, addr);
        end else begin
            send_command(OP_NOP, addr);
        end
    endtask

    task automatic test_random_traffic();
        int unsigned idle_pct [3] = '{0, 78, 27};
        int unsigned mem_kb;
        int unsigned reserved;
        for (int p = 0; p < 6; p++) begin
            case ($urandom_range(3))
                0:       mem_kb = 16384;
                1:       mem_kb = $urandom_range(32767);
                default: mem_kb = $urandom_range(2100);
            endcase
            reserved = ($urandom_range(4) == 0) ? $urandom_range(8191)
                                                : $urandom_range(600);
            set_limits(mem_kb, reserved);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                while ($urandom_range(99) < idle_pct[p % 3])
                    hold_off(1);
                send_random_command();
                if ($urandom_range(99) == 0)
                    drain();
            end
        end
    endtask

    initial begin
        mem_kb_cfg   = RESET_MEM_KB;
        reserved_cfg = RESET_RESERVED;
        reload_map();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_state();
        test_partial_word();
        test_config_extremes();
        test_random_traffic();
        drain();
        $display("Run covered %0d commands and %0d answers: %0d frames granted, %0d refused,",
                 items_sent, answers_seen, frames_given, refusals);
        $display("%0d frames released, %0d register writes across reset, partial and full maps.",
                 frames_freed, reg_writes);
        if (failures == 0)
            $display("** bitmap_frame_allocator: PASSED **");
        else
            $display("** bitmap_frame_allocator: FAILED **");
        $finish;
    end

endmodule

// ===== bitmap_frame_allocator.f =====
+incdir+hw/rtl
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_front.sv
hw/rtl/bfa_queue.sv
hw/rtl/bfa_back.sv
hw/rtl/bitmap_frame_allocator.sv
hw/rtl/bfa_checker.sv
tb/bitmap_frame_allocator_test.sv
